// File: design/spq_pkg.sv
// shared types and constants for the stable priority queue
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic       ACT_ENQ = 1'b0;
    localparam logic       ACT_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] pages;
        logic [7:0]  prio;
    } job_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctl_t;

endpackage

// File: design/spq_cell.sv
// one slot of the sorted queue, shifts toward the head or the tail with its neighbors
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      slot_valid,
    input  job_t      new_job,
    input  logic      prev_after,
    input  job_t      prev_job,
    input  job_t      next_job,
    output logic      after,
    output job_t      job
);

    job_t job_reg;
    job_t job_next;

    // new job goes behind this slot when it holds an equal or more urgent entry
    assign after = slot_valid && (job_reg.prio <= new_job.prio);
    assign job   = job_reg;

    always_comb
    begin
        job_next = job_reg;
        if (ctl.enq)
        begin
            if (after)
                job_next = job_reg;
            else if (prev_after)
                job_next = new_job;
            else
                job_next = prev_job;
        end
        else if (ctl.deq)
        begin
            job_next = next_job;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

// File: design/stable_priority_queue_top.sv
// Stable sorted priority queue built as a row of shifting slot cells.
// One request is taken in every clock cycle (busy stays low): every slot compares
// its priority with the incoming job in parallel and shifts by one slot in that
// same cycle. The result appears with done high on the cycle after the request
// and lasts one cycle; the receiver cannot stall it. Jobs with equal priority
// leave in arrival order. An enqueue to a full queue is dropped with status full,
// a dequeue from an empty queue reports status empty; both leave the queue
// unchanged.
module stable_priority_queue_top
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [15:0] job_id,
    input  logic [15:0] page_count,
    input  logic [7:0]  priority_req,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] out_id,
    output logic [15:0] out_pages,
    output logic [7:0]  out_priority,
    output logic [4:0]  occupancy
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    job_t             out_reg;
    job_t             out_next;

    job_t             new_job;
    cell_ctl_t        ctl;
    logic             accept;
    logic             full;
    logic             empty;

    job_t             jobs  [QUEUE_DEPTH];
    logic             afters[QUEUE_DEPTH];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign new_job = '{id: job_id, pages: page_count, prio: priority_req};

    assign ctl.enq = accept && (action == ACT_ENQ) && !full;
    assign ctl.deq = accept && (action == ACT_DEQ) && !empty;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic slot_valid;
            logic prev_after;
            job_t prev_job;
            job_t next_job;

            assign slot_valid = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign prev_after = 1'b1;
                assign prev_job   = new_job;
            end
            else
            begin : g_body
                assign prev_after = afters[i-1];
                assign prev_job   = jobs[i-1];
            end

            // the tail slot leaves the count on a remove, so its contents do not matter
            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_job = jobs[i];
            end
            else
            begin : g_mid
                assign next_job = jobs[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .slot_valid (slot_valid),
                .new_job    (new_job),
                .prev_after (prev_after),
                .prev_job   (prev_job),
                .next_job   (next_job),
                .after      (afters[i]),
                .job        (jobs[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        out_next    = '0;
        if (accept)
        begin
            case (action)
                ACT_ENQ:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        status_next = ST_ENQUEUED;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        status_next = ST_DEQUEUED;
                        out_next    = jobs[0];
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_id       = out_reg.id;
    assign out_pages    = out_reg.pages;
    assign out_priority = out_reg.prio;
    assign occupancy    = 5'(count_reg);

endmodule
